FILE: rtl/mrss_pkg.sv
// Shared constants, types and a helper function for the Morton range split search block.
package mrss_pkg;

  // Store geometry and field widths.
  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int POS_W     = ADDR_W + 1;
  localparam int CAND_W    = POS_W + 1;
  localparam int CODE_W    = 32;

  // Request modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Search sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_PROBE,
    S_DONE
  } srch_state_t;

  // One result as it travels from the search engine to the output register.
  typedef struct packed {
    logic [POS_W-1:0] split_pos;
    logic             both_nonempty;
    logic             range_error;
  } result_t;

  // Mask of the leading bits up to and including the first set bit of diff.
  // A code shares a longer prefix with the first code exactly when its XOR
  // with the first code is zero under this mask.
  function automatic logic [CODE_W-1:0] prefix_mask(input logic [CODE_W-1:0] diff);
    logic [CODE_W-1:0] smear;
    smear = diff;
    for (int sh = 1; sh < CODE_W; sh = sh * 2) begin
      smear = smear | (smear >> sh);
    end
    return ~(smear >> 1);
  endfunction

endpackage

FILE: rtl/mrss_if.sv
// Request and result channel interfaces of the Morton range split search block.
interface mrss_in_if;
  import mrss_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [ADDR_W-1:0]   position;
  logic [CODE_W-1:0]   code;
  logic [ADDR_W-1:0]   range_begin;
  logic [POS_W-1:0]    range_end;

  modport source (
    output valid, mode, position, code, range_begin, range_end,
    input  ready
  );

  modport sink (
    input  valid, mode, position, code, range_begin, range_end,
    output ready
  );
endinterface

interface mrss_out_if;
  import mrss_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] split_pos;
  logic             both_nonempty;
  logic             range_error;

  modport source (
    output valid, split_pos, both_nonempty, range_error,
    input  ready
  );

  modport sink (
    input  valid, split_pos, both_nonempty, range_error,
    output ready
  );
endinterface

FILE: rtl/mrss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mrss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/mrss_search.sv
// Request decoder and binary split search sequencer around the code store.
module mrss_search (
  input  logic                         clk,
  input  logic                         rst,
  mrss_in_if.sink                      items,
  output logic                         wr_en,
  output logic [mrss_pkg::ADDR_W-1:0]  wr_addr,
  output logic [mrss_pkg::CODE_W-1:0]  wr_data,
  output logic [mrss_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [mrss_pkg::CODE_W-1:0]  rd_data,
  output logic                         res_valid,
  output mrss_pkg::result_t            res,
  input  logic                         res_take
);
  import mrss_pkg::*;

  srch_state_t       state, state_next;
  logic [CODE_W-1:0] first, first_next;
  logic [CODE_W-1:0] mask, mask_next;
  logic              none, none_next;
  logic [POS_W-1:0]  rng_begin, rng_begin_next;
  logic [POS_W-1:0]  rng_end, rng_end_next;
  logic [POS_W-1:0]  split, split_next;
  logic [POS_W-1:0]  step, step_next;
  logic [CAND_W-1:0] cand, cand_next;
  logic              cand_ok, cand_ok_next;
  logic              err, err_next;

  logic              accept;
  logic [POS_W-1:0]  req_begin;
  logic [POS_W-1:0]  len;
  logic [POS_W-1:0]  step_first;
  logic              hit;
  logic [POS_W-1:0]  split_upd;
  logic [POS_W-1:0]  step_upd;
  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  stp;
  logic [CAND_W-1:0] cand_calc;
  logic              cand_fits;
  logic [POS_W-1:0]  last_pos;
  logic [POS_W-1:0]  after;

  assign accept    = items.valid && items.ready;
  assign req_begin = {1'b0, items.range_begin};

  // Load path: the write port is driven straight from the request.
  assign wr_addr = items.position;
  assign wr_data = items.code;

  // First halving step of a fresh range.
  assign len        = rng_end - rng_begin;
  assign step_first = (len + POS_W'(1)) >> 1;

  // Probe compare: a longer shared prefix means a zero XOR under the mask.
  // Identical end codes leave nothing longer than the common prefix.
  assign hit       = cand_ok && !none && (((first ^ rd_data) & mask) == '0);
  assign split_upd = hit ? cand[POS_W-1:0] : split;
  assign step_upd  = (step + POS_W'(1)) >> 1;

  // Next candidate position, shared by the first probe and the later ones.
  assign base      = (state == S_LAST) ? rng_begin : split_upd;
  assign stp       = (state == S_LAST) ? step_first : step_upd;
  assign cand_calc = CAND_W'(base) + CAND_W'(stp);
  assign cand_fits = cand_calc < CAND_W'(rng_end);

  assign last_pos = rng_end - POS_W'(1);

  // Result fields, formed from the held search state.
  assign after                = split + POS_W'(1);
  assign res.split_pos        = err ? '0 : after;
  assign res.both_nonempty    = !err && (after > rng_begin) && (rng_end > after);
  assign res.range_error      = err;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath registers.
  always_ff @(posedge clk) begin
    first     <= first_next;
    mask      <= mask_next;
    none      <= none_next;
    rng_begin <= rng_begin_next;
    rng_end   <= rng_end_next;
    split     <= split_next;
    step      <= step_next;
    cand      <= cand_next;
    cand_ok   <= cand_ok_next;
    err       <= err_next;
  end

  // Next state, datapath updates and memory addressing.
  always_comb begin
    state_next     = state;
    first_next     = first;
    mask_next      = mask;
    none_next      = none;
    rng_begin_next = rng_begin;
    rng_end_next   = rng_end;
    split_next     = split;
    step_next      = step;
    cand_next      = cand;
    cand_ok_next   = cand_ok;
    err_next       = err;
    items.ready    = 1'b0;
    wr_en          = 1'b0;
    res_valid      = 1'b0;
    rd_addr        = cand_calc[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        items.ready = 1'b1;
        // Start reading the first code as the query comes in.
        rd_addr = items.range_begin;
        if (accept) begin
          if (items.mode == MODE_LOAD) begin
            wr_en = {1'b0, items.position} < POS_W'(MAX_ITEMS);
          end else begin
            rng_begin_next = req_begin;
            rng_end_next   = items.range_end;
            if ((items.range_end <= req_begin) ||
                (items.range_end > POS_W'(MAX_ITEMS))) begin
              err_next   = 1'b1;
              state_next = S_DONE;
            end else begin
              err_next   = 1'b0;
              state_next = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        first_next = rd_data;
        rd_addr    = last_pos[ADDR_W-1:0];
        state_next = S_LAST;
      end
      S_LAST: begin
        // Common prefix of the range, kept as a mask of leading bits.
        mask_next    = prefix_mask(first ^ rd_data);
        none_next    = (first == rd_data);
        split_next   = rng_begin;
        step_next    = step_first;
        cand_next    = cand_calc;
        cand_ok_next = cand_fits;
        state_next   = S_PROBE;
      end
      S_PROBE: begin
        split_next = split_upd;
        if (step > POS_W'(1)) begin
          step_next    = step_upd;
          cand_next    = cand_calc;
          cand_ok_next = cand_fits;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/morton_range_split_search.sv
// Top level of the Morton range split search block: code store, search engine, result register.
//
//   Channel   Dir  Contents
//   items     in   mode, position, code, range_begin, range_end
//   results   out  split_pos, both_nonempty, range_error
//
// A load request is taken while the engine is idle and writes the code store directly.
// A query occupies the search engine while it reads the first and last codes of the
// range and then halves n = range_end - range_begin; each halving step waits on one
// read of the code store, so the chain of dependent RAM reads sets how long it runs.
// A rejected range goes straight to a result without reading the store. Reset is
// synchronous and clears only control state; the code store holds no meaningful
// value until written. A result waits in the output register while the next request
// is taken, and the engine holds its finished result only while that register is
// full and not drained.
module morton_range_split_search (
  input  logic      clk,
  input  logic      rst,
  mrss_in_if.sink   items,
  mrss_out_if.source results
);
  import mrss_pkg::*;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [CODE_W-1:0] rd_data;
  logic              res_valid;
  result_t           res;
  logic              res_take;
  logic              out_valid;
  result_t           out_res;

  // Sorted code store.
  mrss_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request decoder and split search.
  mrss_search u_search (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: refilled whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign results.valid         = out_valid;
  assign results.split_pos     = out_res.split_pos;
  assign results.both_nonempty = out_res.both_nonempty;
  assign results.range_error   = out_res.range_error;

  // A query keeps the engine busy for at least the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && (items.mode == MODE_QUERY)) |=> !items.ready)
    else $error("request taken while a query is in progress");

  // A load finishes in its own cycle and leaves the engine free.
  assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && (items.mode == MODE_LOAD)) |=> items.ready)
    else $error("load request stalled the engine");

  // A rejected range carries no split.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.range_error) |-> ((res.split_pos == '0) && !res.both_nonempty))
    else $error("rejected range reported a split");

  // An accepted range always splits past its first entry.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.range_error) |-> (res.split_pos != '0))
    else $error("valid range reported a zero split position");

endmodule
